[src/imusc_pkg.sv]
package imusc_pkg;

  // Register map of the configuration port
  typedef enum logic [2:0] {
    CFG_SENSOR_KIND     = 3'd0,
    CFG_ORIENT_MATRIX   = 3'd1,
    CFG_CAL_X           = 3'd2,
    CFG_CAL_Y           = 3'd3,
    CFG_CAL_Z           = 3'd4,
    CFG_SELFTEST_MODE   = 3'd5,
    CFG_SELFTEST_DELTAS = 3'd6,
    CFG_POLL_PERIOD     = 3'd7
  } cfg_reg_t;

  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 48;
  localparam int unsigned AxisW    = 16;
  localparam int unsigned TimeW    = 63;
  localparam int unsigned PollW    = 10;
  localparam int unsigned ThrW     = 31;

  localparam int unsigned SKIP_SAMPLES_DEF = 10;

  // Sensor kind codes
  localparam logic KIND_ACCEL = 1'b0;
  localparam logic KIND_GYRO  = 1'b1;

  // Self-test correction codes
  localparam logic [1:0] ST_ADD = 2'd1;
  localparam logic [1:0] ST_SUB = 2'd2;

  // Orientation entry codes; anything else acts as zero
  localparam logic [1:0] ORIENT_PLUS  = 2'd1;
  localparam logic [1:0] ORIENT_MINUS = 2'd3;

  localparam logic [AxisW-1:0] AXIS_MIN     = 16'h8000;
  localparam logic [AxisW-1:0] AXIS_MIN_CLP = 16'h8001;

  localparam logic [20:0]      GAP_NS_PER_MS  = 21'd1800000;
  localparam logic [TimeW-1:0] SKIP_WINDOW_NS = 63'd80000000;
  localparam logic [PollW-1:0] POLL_RESET     = 10'd10;
  localparam logic [ThrW-1:0]  THR_RESET      = 31'd18000000;

  typedef struct packed {
    logic signed [AxisW-1:0] raw_x;
    logic signed [AxisW-1:0] raw_y;
    logic signed [AxisW-1:0] raw_z;
    logic [TimeW-1:0]        sample_time;
    logic                    arm_skip;
  } imu_in_t;

  typedef struct packed {
    logic signed [AxisW-1:0] out_x;
    logic signed [AxisW-1:0] out_y;
    logic signed [AxisW-1:0] out_z;
    logic [TimeW-1:0]        out_time;
    logic                    gap_fill;
    logic                    is_last;
  } imu_out_t;

  // One orientation term: +v, -v or zero
  function automatic logic [AxisW-1:0] orient_term(input logic [1:0] code,
                                                   input logic [AxisW-1:0] v);
    logic [AxisW-1:0] res;
    begin
      unique case (code)
        ORIENT_PLUS:  res = v;
        ORIENT_MINUS: res = AxisW'(0) - v;
        default:      res = '0;
      endcase
      return res;
    end
  endfunction

endpackage

[src/imu_sample_conditioner_unit.sv]
// An accepted sample is held in the input register, then in the result register, which
// drives out_valid and out_data.
// Throughput: one sample per cycle while out_stall is low; a sample that opens a time gap yields a gap-fill beat
// and then its main beat, so it holds the result register until both beats have left.
// Reset (rst_n low, synchronous): channels empty, timing and skip state cleared,
// configuration registers back to their reset values (poll period 10 ms).
module imu_sample_conditioner_unit
  import imusc_pkg::*;
#(
  parameter int unsigned SKIP_SAMPLES = SKIP_SAMPLES_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  imu_in_t             in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output imu_out_t            out_data,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [CfgIdxW-1:0]  cfg_index,
  input  logic [CfgDataW-1:0] cfg_data
);

  localparam int unsigned SkipCntW = $clog2(SKIP_SAMPLES + 1);
  localparam logic [SkipCntW-1:0] SkipLast = SkipCntW'(SKIP_SAMPLES);

  // Configuration registers
  logic               kind_r;
  logic [17:0]        orient_r;
  logic [AxisW-1:0]   cal_r [3];
  logic [1:0]         st_mode_r;
  logic [CfgDataW-1:0] deltas_r;
  logic [PollW-1:0]   poll_r;
  logic [ThrW-1:0]    thr_r;

  // Pipeline registers
  logic               a_valid_r;
  imu_in_t            a_data_r;
  logic               out_valid_r;
  imu_out_t           out_data_r;
  logic               pend_r;
  logic [TimeW-1:0]   main_time_r;

  // Timing and skip state
  logic [TimeW-1:0]   prev_time_r;
  logic               skipping_r;
  logic [SkipCntW-1:0] skip_cnt_r;
  logic [TimeW-1:0]   skip_start_r;

  logic               gyro;
  logic               out_free;
  logic               advance;
  logic [AxisW-1:0]   raw [3];
  logic [AxisW-1:0]   axis [3];
  logic [AxisW-1:0]   res [3];
  logic [AxisW-1:0]   sum;
  logic [TimeW-1:0]   t;
  logic               skip_eff;
  logic               skip_zero;
  logic [TimeW-1:0]   start_eff;
  logic [TimeW:0]     el;
  logic [SkipCntW-1:0] cnt_inc;
  logic               skip_end;
  logic [TimeW:0]     gap_diff;
  logic               gap;
  logic [TimeW:0]     mid_sum;
  imu_out_t           beat_nxt;

  assign cfg_ready = 1'b1;
  assign gyro      = (kind_r == KIND_GYRO);

  // Handshake: the result register frees when it is empty, or when its beat leaves and no main beat waits
  assign out_free  = !out_valid_r || (!out_stall && !pend_r);
  assign advance   = a_valid_r && out_free;
  assign in_stall  = a_valid_r && !out_free;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // Axis path: self-test, clamp, calibration and orientation
  assign raw[0] = a_data_r.raw_x;
  assign raw[1] = a_data_r.raw_y;
  assign raw[2] = a_data_r.raw_z;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      axis[k] = raw[k];
      if (gyro && st_mode_r == ST_ADD) begin
        axis[k] = raw[k] + deltas_r[16*k +: 16];
      end else if (gyro && st_mode_r == ST_SUB) begin
        axis[k] = raw[k] - deltas_r[16*k +: 16];
      end
      if (axis[k] == AXIS_MIN) begin
        axis[k] = AXIS_MIN_CLP;
      end
      if (gyro) begin
        axis[k] = axis[k] - cal_r[k];
      end
    end
  end

  always_comb begin
    sum = '0;
    for (int j = 0; j < 3; j++) begin
      sum = orient_term(orient_r[2*j +: 2], axis[0])
          + orient_term(orient_r[2*(3+j) +: 2], axis[1])
          + orient_term(orient_r[2*(6+j) +: 2], axis[2]);
      res[j] = gyro ? sum : (sum - cal_r[j]);
      if (skip_zero) begin
        res[j] = '0;
      end
    end
  end

  // Skip window: zero the gyro output until the count or the time runs out
  assign t         = a_data_r.sample_time;
  assign skip_eff  = skipping_r || a_data_r.arm_skip;
  assign skip_zero = gyro && skip_eff;
  assign start_eff = (skip_cnt_r == '0) ? t : skip_start_r;
  assign el        = {1'b0, t} - {1'b0, start_eff};
  assign cnt_inc   = skip_cnt_r + SkipCntW'(1);
  assign skip_end  = (!el[TimeW] && el[TimeW-1:0] >= SKIP_WINDOW_NS) || (cnt_inc == SkipLast);

  // Gap detection against the precomputed threshold
  assign gap_diff = {1'b0, t} - {1'b0, prev_time_r};
  assign gap      = (prev_time_r != '0) && !gap_diff[TimeW]
                    && (gap_diff[TimeW-1:0] > {{(TimeW-ThrW){1'b0}}, thr_r});
  assign mid_sum  = {1'b0, t} + {1'b0, prev_time_r};

  always_comb begin
    beat_nxt.out_x    = res[0];
    beat_nxt.out_y    = res[1];
    beat_nxt.out_z    = res[2];
    beat_nxt.out_time = gap ? mid_sum[TimeW:1] : t;
    beat_nxt.gap_fill = gap;
    beat_nxt.is_last  = !gap;
  end

  // Configuration writes and the gap threshold
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      kind_r    <= KIND_ACCEL;
      orient_r  <= '0;
      cal_r[0]  <= '0;
      cal_r[1]  <= '0;
      cal_r[2]  <= '0;
      st_mode_r <= '0;
      deltas_r  <= '0;
      poll_r    <= POLL_RESET;
      thr_r     <= THR_RESET;
    end else begin
      thr_r <= ThrW'({{(ThrW-PollW){1'b0}}, poll_r} * {{(ThrW-21){1'b0}}, GAP_NS_PER_MS});
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_reg_t'(cfg_index))
          CFG_SENSOR_KIND:     kind_r    <= cfg_data[0];
          CFG_ORIENT_MATRIX:   orient_r  <= cfg_data[17:0];
          CFG_CAL_X:           cal_r[0]  <= cfg_data[AxisW-1:0];
          CFG_CAL_Y:           cal_r[1]  <= cfg_data[AxisW-1:0];
          CFG_CAL_Z:           cal_r[2]  <= cfg_data[AxisW-1:0];
          CFG_SELFTEST_MODE:   st_mode_r <= cfg_data[1:0];
          CFG_SELFTEST_DELTAS: deltas_r  <= cfg_data;
          CFG_POLL_PERIOD:     poll_r    <= cfg_data[PollW-1:0];
        endcase
      end
    end
  end

  // Input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r <= 1'b0;
    end else if (!in_stall) begin
      a_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      a_data_r <= in_data;
    end
  end

  // Result register: gap-fill beat first, then the held main beat
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      pend_r      <= 1'b0;
    end else if (advance) begin
      out_valid_r <= 1'b1;
      pend_r      <= gap;
    end else if (out_valid_r && !out_stall) begin
      out_valid_r <= pend_r;
      pend_r      <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_data_r  <= beat_nxt;
      main_time_r <= t;
    end else if (out_valid_r && !out_stall && pend_r) begin
      out_data_r.out_time <= main_time_r;
      out_data_r.gap_fill <= 1'b0;
      out_data_r.is_last  <= 1'b1;
    end
  end

  // Advance timing and skip state as each sample moves into the result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_time_r  <= '0;
      skipping_r   <= 1'b0;
      skip_cnt_r   <= '0;
      skip_start_r <= '0;
    end else if (advance) begin
      prev_time_r <= t;
      if (skip_zero) begin
        if (skip_end) begin
          skipping_r   <= 1'b0;
          skip_cnt_r   <= '0;
          skip_start_r <= '0;
        end else begin
          skipping_r   <= 1'b1;
          skip_cnt_r   <= cnt_inc;
          skip_start_r <= start_eff;
        end
      end else if (a_data_r.arm_skip) begin
        skipping_r <= 1'b1;
      end
    end
  end

  // Checks
  a_fill_then_main: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.gap_fill && !out_stall
      |=> out_valid && !out_data.gap_fill && out_data.is_last)
    else $error("gap-fill beat not followed by its main beat");

  a_pend_on_fill: assert property (@(posedge clk) disable iff (!rst_n)
    pend_r |-> out_valid_r && out_data_r.gap_fill && !out_data_r.is_last)
    else $error("main beat pending without a gap-fill beat on the output");

  a_skip_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    skip_cnt_r < SkipLast)
    else $error("skip counter passed the window length");

  a_stall_needs_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> a_valid_r && out_valid_r)
    else $error("input stalled with an empty pipeline");

endmodule
